@@ hw/rtl/rih_pkg.sv @@
// ----------------------------------------------------------------------------
// rih_pkg
// Shared types, codes, seeds and the byte-fold function of the resource id
// hasher (64-bit FNV-1a over path bytes and derived/duplicate source words).
// ----------------------------------------------------------------------------
package rih_pkg;

    // default command queue depth and the fixed result queue depth
    localparam int unsigned CMD_DEPTH_DEF = 4;
    localparam int unsigned RES_DEPTH     = 2;

    // operation and result-kind codes
    typedef logic [1:0] t_op;
    localparam t_op OP_PATH  = 2'd0;
    localparam t_op OP_DERIV = 2'd1;
    localparam t_op OP_DUP   = 2'd2;

    localparam t_op KIND_PATH  = 2'd0;
    localparam t_op KIND_DERIV = 2'd1;
    localparam t_op KIND_DUP   = 2'd2;

    // hash seeds
    localparam logic [63:0] SEED_A     = 64'hcbf29ce484222325;
    localparam logic [63:0] SEED_B     = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] SEED_DERIV = 64'h2545f4914f6cdd1d;
    localparam logic [63:0] SEED_DUP   = 64'h8ebc6af09c88c6e3;

    // the walk takes 16 byte steps: source id and tag, then four zero bytes
    localparam int unsigned WALK_STEPS = 16;

    // classified word from the front to the back
    typedef struct packed {
        t_op         op;
        logic [7:0]  path_byte;
        logic        present;
        logic        last;
        logic [63:0] source_id;
        logic [31:0] tag;
    } t_cmd;

    // one result word
    typedef struct packed {
        logic [63:0] primary;
        logic [63:0] secondary;
        t_op         kind;
    } t_res;

    // xor the byte, then multiply by the fnv prime 2^40 + 0x1b3 mod 2^64;
    // 0x1b3 has bits 8, 7, 5, 4, 1 and 0 set
    function automatic logic [63:0] fold_byte(input logic [63:0] acc,
                                              input logic [7:0]  data);
        logic [63:0] x;
        x = acc ^ {56'd0, data};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

    // a hash of zero is reported as one
    function automatic logic [63:0] never_zero(input logic [63:0] v);
        return (v == 64'd0) ? 64'd1 : v;
    endfunction

endpackage

@@ hw/rtl/resource_id_hasher.sv @@
// ----------------------------------------------------------------------------
// resource_id_hasher
// 64-bit FNV-1a resource identities: a pair of path hashes (two seeds) built
// byte by byte, and derived/duplicate ids from a source id and a 32-bit tag.
//
//   channel  | handshake        | fields
//   ---------+------------------+-------------------------------------------
//   input    | push / full      | operation, path_byte, byte_present,
//            |                  | last_byte, source_id, tag_value
//   result   | empty / pop      | rid_primary, rid_secondary, result_kind
//
// A path byte passes through the hash engine without a walk; a derived or
// duplicate word holds the engine while it is taken and then walked in 16 steps
// of one byte each through the shared fold unit.
// The command queue (CMD_DEPTH words) absorbs input while the engine walks;
// the two-entry result queue lets the engine go on while a result waits.
// Reset is synchronous; both path hashes return to their seeds, queues empty.
// Words that do nothing (no byte, not last, or an undefined operation) are
// accepted and dropped.
// ----------------------------------------------------------------------------
module resource_id_hasher #(
    parameter int unsigned CMD_DEPTH = rih_pkg::CMD_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_path_byte,
    input  logic        i_byte_present,
    input  logic        i_last_byte,
    input  logic [63:0] i_source_id,
    input  logic [31:0] i_tag_value,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] o_rid_primary,
    output logic [63:0] o_rid_secondary,
    output logic [1:0]  o_result_kind
);
    import rih_pkg::*;

    logic w_cmd_valid, w_cmd_ready;
    t_cmd w_cmd;
    logic w_res_push, w_res_full;
    t_res w_res_in, w_res_out;

    // front: classify and queue
    rih_front #(
        .CMD_DEPTH (CMD_DEPTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_operation    (i_operation),
        .i_path_byte    (i_path_byte),
        .i_byte_present (i_byte_present),
        .i_last_byte    (i_last_byte),
        .i_source_id    (i_source_id),
        .i_tag_value    (i_tag_value),
        .o_cmd_valid    (w_cmd_valid),
        .o_cmd          (w_cmd),
        .i_cmd_ready    (w_cmd_ready)
    );

    // back: hash engine
    rih_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_ready (w_cmd_ready),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in),
        .i_res_full  (w_res_full)
    );

    // result queue
    rih_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res_push (w_res_push),
        .i_res      (w_res_in),
        .o_res_full (w_res_full),
        .empty      (empty),
        .pop        (pop),
        .o_res      (w_res_out)
    );

    assign o_rid_primary   = w_res_out.primary;
    assign o_rid_secondary = w_res_out.secondary;
    assign o_result_kind   = w_res_out.kind;

endmodule

@@ hw/rtl/rih_front.sv @@
// ----------------------------------------------------------------------------
// rih_front
// Accepts input words, drops those that do nothing (idle path elements and
// undefined operations) and queues the rest for the hash engine.
// ----------------------------------------------------------------------------
module rih_front #(
    parameter int unsigned CMD_DEPTH = rih_pkg::CMD_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  logic [1:0]    i_operation,
    input  logic [7:0]    i_path_byte,
    input  logic          i_byte_present,
    input  logic          i_last_byte,
    input  logic [63:0]   i_source_id,
    input  logic [31:0]   i_tag_value,
    output logic          o_cmd_valid,
    output rih_pkg::t_cmd o_cmd,
    input  logic          i_cmd_ready
);
    import rih_pkg::*;

    localparam int unsigned PW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int unsigned CW = $clog2(CMD_DEPTH + 1);

    t_cmd          r_mem [CMD_DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          w_acc, w_keep, w_wr, w_rd;
    t_cmd          w_cmd;

    // classify the incoming word
    always_comb begin
        w_keep = 1'b0;
        unique case (i_operation) inside
            OP_PATH:          w_keep = i_byte_present | i_last_byte;
            OP_DERIV, OP_DUP: w_keep = 1'b1;
            default:          w_keep = 1'b0;
        endcase
    end

    assign w_cmd = '{op: i_operation, path_byte: i_path_byte, present: i_byte_present,
                     last: i_last_byte, source_id: i_source_id, tag: i_tag_value};

    assign full        = (r_count == CW'(CMD_DEPTH));
    assign w_acc       = push & ~full;
    assign w_wr        = w_acc & w_keep;
    assign o_cmd_valid = (r_count != '0);
    assign w_rd        = o_cmd_valid & i_cmd_ready;
    assign o_cmd       = r_mem[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PW'(CMD_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PW'(CMD_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (!w_wr && w_rd) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= w_cmd;
        end
    end

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CMD_DEPTH))
        else $error("command queue over depth");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr && !w_rd) |=> r_count == $past(r_count) + 1'b1)
        else $error("command queue count did not grow");
    a_drop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !w_keep) |=> r_count == $past(r_count) - CW'($past(w_rd)))
        else $error("dropped word entered the queue");

endmodule

@@ hw/rtl/rih_back.sv @@
// ----------------------------------------------------------------------------
// rih_back
// Hash engine: folds path bytes into the two running hashes, and walks the
// 16 bytes of a derived or duplicate item through the same fold unit.
// ----------------------------------------------------------------------------
module rih_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  rih_pkg::t_cmd i_cmd,
    output logic          o_cmd_ready,
    output logic          o_res_push,
    output rih_pkg::t_res o_res,
    input  logic          i_res_full
);
    import rih_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;
    localparam int unsigned SW = $clog2(WALK_STEPS);

    logic          r_state, n_state;
    logic [63:0]   r_hash_a, n_hash_a;
    logic [63:0]   r_hash_b, n_hash_b;
    logic [63:0]   r_acc, n_acc;
    logic [127:0]  r_data, n_data;
    logic [SW-1:0] r_step, n_step;
    t_op           r_kind, n_kind;
    logic [63:0]   w_fold_in;
    logic [7:0]    w_fold_byte;
    logic [63:0]   w_fold_a, w_fold_b;
    logic          w_take, w_last_step;

    // shared fold unit: running hash a in idle, the walk accumulator otherwise
    assign w_fold_in   = (r_state == ST_WALK) ? r_acc : r_hash_a;
    assign w_fold_byte = (r_state == ST_WALK) ? r_data[7:0] : i_cmd.path_byte;
    assign w_fold_a    = fold_byte(w_fold_in, w_fold_byte);
    assign w_fold_b    = fold_byte(r_hash_b, i_cmd.path_byte);

    // a path byte that closes nothing never needs result space
    assign o_cmd_ready = (r_state == ST_IDLE) &&
                         ((i_cmd.op == OP_PATH && !i_cmd.last) || !i_res_full);
    assign w_take      = i_cmd_valid & o_cmd_ready;
    assign w_last_step = (r_step == SW'(WALK_STEPS - 1));

    // engine control
    always_comb begin
        n_state    = r_state;
        n_hash_a   = r_hash_a;
        n_hash_b   = r_hash_b;
        n_acc      = r_acc;
        n_data     = r_data;
        n_step     = r_step;
        n_kind     = r_kind;
        o_res_push = 1'b0;
        o_res      = '{primary: never_zero(w_fold_a), secondary: 64'd0, kind: r_kind};
        unique case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    if (i_cmd.op == OP_PATH) begin
                        if (i_cmd.present) begin
                            n_hash_a = w_fold_a;
                            n_hash_b = w_fold_b;
                        end
                        if (i_cmd.last) begin
                            o_res_push = 1'b1;
                            o_res      = '{primary:   never_zero(n_hash_a),
                                           secondary: never_zero(n_hash_b),
                                           kind:      KIND_PATH};
                            n_hash_a   = SEED_A;
                            n_hash_b   = SEED_B;
                        end
                    end else begin
                        n_acc   = (i_cmd.op == OP_DERIV) ? SEED_DERIV : SEED_DUP;
                        n_data  = {32'd0, i_cmd.tag, i_cmd.source_id};
                        n_step  = '0;
                        n_kind  = (i_cmd.op == OP_DERIV) ? KIND_DERIV : KIND_DUP;
                        n_state = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (!w_last_step) begin
                    n_acc  = w_fold_a;
                    n_data = r_data >> 8;
                    n_step = r_step + 1'b1;
                end else if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_step     = '0;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_hash_a <= SEED_A;
            r_hash_b <= SEED_B;
            r_step   <= '0;
            r_kind   <= KIND_DERIV;
        end else begin
            r_state  <= n_state;
            r_hash_a <= n_hash_a;
            r_hash_b <= n_hash_b;
            r_step   <= n_step;
            r_kind   <= n_kind;
        end
    end

    // walk payload
    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_data <= n_data;
    end

    // checks
    a_walk_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> !o_cmd_ready)
        else $error("command taken during a walk");
    a_walk_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_cmd.op != OP_PATH) |=> (r_state == ST_WALK && r_step == '0))
        else $error("walk did not start from step zero");
    a_idle_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_step == '0))
        else $error("step counter left over in idle");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result pushed into a full queue");

endmodule

@@ hw/rtl/rih_out.sv @@
// ----------------------------------------------------------------------------
// rih_out
// Two-entry result queue between the hash engine and the consumer.
// ----------------------------------------------------------------------------
module rih_out (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_res_push,
    input  rih_pkg::t_res i_res,
    output logic          o_res_full,
    output logic          empty,
    input  logic          pop,
    output rih_pkg::t_res o_res
);
    import rih_pkg::*;

    localparam int unsigned PW = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
    localparam int unsigned CW = $clog2(RES_DEPTH + 1);

    t_res          r_mem [RES_DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          w_rd;

    assign o_res_full = (r_count == CW'(RES_DEPTH));
    assign empty      = (r_count == '0);
    assign w_rd       = pop & ~empty;
    assign o_res      = r_mem[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_res_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(RES_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PW'(RES_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_res_push && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (!i_res_push && w_rd) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // result storage
    always_ff @(posedge i_clk) begin
        if (i_res_push) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(RES_DEPTH))
        else $error("result queue over depth");
    a_head_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> $stable(o_res))
        else $error("waiting result changed");
    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rd && !i_res_push) |=> r_count == $past(r_count) - 1'b1)
        else $error("result queue count did not drop");

endmodule
